@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Concurrent check on clk_i, idle while rst_ni is low
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication check: when pre holds, post holds on the same edge
`define ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

@@ rtl/core/csj_pkg.sv @@
package csj_pkg;

  // Default width of the running reference position
  localparam int unsigned PositionWidthDef = 31;

  // Fixed field widths of the stream items
  localparam int unsigned OpCodeW  = 4;
  localparam int unsigned OpLenW   = 28;
  localparam int unsigned PosOutW  = 31;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 64;

  // CIGAR op codes
  localparam logic [OpCodeW-1:0] OpMatch    = 4'd0;
  localparam logic [OpCodeW-1:0] OpIns      = 4'd1;
  localparam logic [OpCodeW-1:0] OpDel      = 4'd2;
  localparam logic [OpCodeW-1:0] OpSkip     = 4'd3;
  localparam logic [OpCodeW-1:0] OpSoft     = 4'd4;
  localparam logic [OpCodeW-1:0] OpHard     = 4'd5;
  localparam logic [OpCodeW-1:0] OpPad      = 4'd6;
  localparam logic [OpCodeW-1:0] OpSeqMatch = 4'd7;
  localparam logic [OpCodeW-1:0] OpSeqMism  = 4'd8;

  // Result kinds
  localparam logic KindJunction = 1'b0;
  localparam logic KindReadEnd  = 1'b1;

  // One op as held in the input register
  typedef struct packed {
    logic [OpCodeW-1:0] op_code;
    logic [OpLenW-1:0]  op_length;
    logic               first_op;
    logic               last_op;
    logic [PosOutW-1:0] read_start;
  } op_item_t;

  // Result of one walk step
  typedef struct packed {
    logic               valid;
    logic               result_kind;
    logic [PosOutW-1:0] first_position;
    logic [PosOutW-1:0] second_position;
    logic               end_of_read;
  } walk_res_t;

  // Ops that move along the reference
  function automatic logic consumes_ref(logic [OpCodeW-1:0] code);
    return (code == OpMatch) || (code == OpDel) || (code == OpSkip) ||
           (code == OpSeqMatch) || (code == OpSeqMism);
  endfunction

endpackage

@@ rtl/core/csj_walk.sv @@
module csj_walk import csj_pkg::*; #(
  parameter int unsigned PositionWidth = PositionWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,   // commit this op to the walk state
  input  op_item_t  op_i,
  output walk_res_t res_o
);

  localparam int unsigned SumW = ((PositionWidth > OpLenW) ? PositionWidth : OpLenW) + 1;
  localparam int unsigned ExtW = (PositionWidth > PosOutW) ? PositionWidth : PosOutW;
  localparam logic [SumW-1:0] PosMax = SumW'({PositionWidth{1'b1}});

  logic [PositionWidth-1:0] ref_pos_q, ref_pos_d;
  logic [PositionWidth-1:0] start_pos_q, start_pos_d;
  logic [PositionWidth-1:0] pos_base;
  logic [ExtW-1:0]          start_ext;
  logic [SumW-1:0]          sum;
  logic [ExtW-1:0]          before_ext, after_ext, startp_ext;

  // Load a new read's start, then advance with saturation
  always_comb begin
    start_ext   = ExtW'(op_i.read_start);
    pos_base    = op_i.first_op ? start_ext[PositionWidth-1:0] : ref_pos_q;
    start_pos_d = op_i.first_op ? start_ext[PositionWidth-1:0] : start_pos_q;
    sum         = SumW'(pos_base) + SumW'(op_i.op_length);
    ref_pos_d   = pos_base;
    if (consumes_ref(op_i.op_code)) begin
      ref_pos_d = (sum > PosMax) ? PositionWidth'(PosMax) : sum[PositionWidth-1:0];
    end
  end

  // Result selection: read end wins over a junction
  always_comb begin
    before_ext = ExtW'(pos_base);
    after_ext  = ExtW'(ref_pos_d);
    startp_ext = ExtW'(start_pos_d);
    res_o.second_position = after_ext[PosOutW-1:0];
    if (op_i.last_op) begin
      res_o.valid          = 1'b1;
      res_o.result_kind    = KindReadEnd;
      res_o.first_position = startp_ext[PosOutW-1:0];
      res_o.end_of_read    = 1'b1;
    end else begin
      res_o.valid          = !op_i.first_op && (op_i.op_code == OpSkip);
      res_o.result_kind    = KindJunction;
      res_o.first_position = before_ext[PosOutW-1:0];
      res_o.end_of_read    = 1'b0;
    end
  end

  // Walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_pos_q   <= '0;
      start_pos_q <= '0;
    end else if (step_i) begin
      ref_pos_q   <= ref_pos_d;
      start_pos_q <= start_pos_d;
    end
  end

endmodule

@@ rtl/core/cigar_splice_junction_walker.sv @@
// Channel | Dir | tdata (low bit up)                        | tuser       | tlast
// s_axis  | in  | op_code, op_length, read_start, zero pad  | first_op    | last_op
// m_axis  | out | first_position, second_position, pad     | result_kind | end_of_read
//
// One op per cycle sustained while m_axis takes the results; an accepted op first sits
// in the input register, then its result, if it gives one, enters the output register.
// The running position is advanced by a single saturating add.
// Reset clears the running and start positions to zero and empties both stages.
// While a result waits on m_axis_tready, ops that give no result still drain;
// an op with a result holds in the input register until the output frees up.
`include "assert_macros.svh"
module cigar_splice_junction_walker import csj_pkg::*; #(
  parameter int unsigned PositionWidth = PositionWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // op_code, op_length, read_start
  input  logic                s_axis_tuser,   // first_op
  input  logic                s_axis_tlast,   // last_op
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // first_position, second_position
  output logic                m_axis_tuser,   // result_kind
  output logic                m_axis_tlast    // end_of_read
);

  logic      in_vld_q;
  op_item_t  in_q, in_d;
  walk_res_t res;
  walk_res_t out_q;
  logic      out_vld_q;
  logic      out_free;
  logic      s1_adv;

  // Unpack the input item
  always_comb begin
    in_d.op_code    = s_axis_tdata[3:0];
    in_d.op_length  = s_axis_tdata[31:4];
    in_d.read_start = s_axis_tdata[62:32];
    in_d.first_op   = s_axis_tuser;
    in_d.last_op    = s_axis_tlast;
  end

  // Stage handshakes
  assign out_free      = !out_vld_q || m_axis_tready;
  assign s1_adv        = in_vld_q && (!res.valid || out_free);
  assign s_axis_tready = !in_vld_q || s1_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_d;
    end
  end

  csj_walk #(
    .PositionWidth(PositionWidth)
  ) u_walk (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(s1_adv),
    .op_i  (in_q),
    .res_o (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s1_adv && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_adv && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q.second_position, out_q.first_position};
  assign m_axis_tuser  = out_q.result_kind;
  assign m_axis_tlast  = out_q.end_of_read;

  // Checks
  `ASSERT_IMPL(a_kind_eor, m_axis_tvalid, m_axis_tuser == m_axis_tlast, "kind and end flag differ")
  `ASSERT_IMPL(a_busy_holds, !s_axis_tready, in_vld_q && res.valid && !out_free, "stall without cause")
  `ASSERT_CLK(a_held_op_stays, (in_vld_q && !s1_adv) |=> in_vld_q, "held op was lost")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import csj_pkg::*;

  localparam int unsigned PosW = PositionWidthDef;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
  localparam logic [OpCodeW-1:0] OpUndefFirst = OpSeqMism + OpCodeW'(1);
  localparam logic [OpCodeW-1:0] OpUndefLast = {OpCodeW{1'b1}};
  localparam logic [OpLenW-1:0] LenMax = {OpLenW{1'b1}};
  localparam logic [PosOutW-1:0] StartMax = {PosOutW{1'b1}};
  localparam int unsigned RandomOps = 450;

  // One result item as seen on m_axis
  typedef struct {
    logic               kind;
    logic [PosOutW-1:0] first_pos;
    logic [PosOutW-1:0] second_pos;
    logic               read_done;
  } walk_out_t;

  // Walks the CIGAR ops itself and keeps the junction / read-end items due
  class junction_scoreboard;
    logic [PosW-1:0] ref_pos;
    logic [PosW-1:0] read_begin;
    walk_out_t       due_results[$];
    int              errors;

    function new();
      ref_pos    = '0;
      read_begin = '0;
      errors     = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Reference-consuming ops: M, D, N, =, X
    function bit moves_on_ref(logic [OpCodeW-1:0] code);
      case (code)
        OpMatch, OpDel, OpSkip, OpSeqMatch, OpSeqMism: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // Advance the walk by one accepted op and queue the item it yields
    function void walk_op(logic [OpCodeW-1:0] code, logic [OpLenW-1:0] len,
                          logic first, logic last, logic [PosOutW-1:0] start);
      logic [PosW-1:0] pos_before;
      logic [PosW:0]   sum;
      walk_out_t       res;
      if (first) begin
        ref_pos    = PosW'(start);
        read_begin = PosW'(start);
      end
      pos_before = ref_pos;
      if (moves_on_ref(code)) begin
        sum     = {1'b0, ref_pos} + (PosW+1)'(len);
        ref_pos = sum[PosW] ? PosMax : sum[PosW-1:0];
      end
      if (last) begin
        res.kind       = KindReadEnd;
        res.first_pos  = PosOutW'(read_begin);
        res.second_pos = PosOutW'(ref_pos);
        res.read_done  = 1'b1;
        due_results.insert(due_results.size(), res);
      end else if (!first && code == OpSkip) begin
        res.kind       = KindJunction;
        res.first_pos  = PosOutW'(pos_before);
        res.second_pos = PosOutW'(ref_pos);
        res.read_done  = 1'b0;
        due_results.insert(due_results.size(), res);
      end
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one accepted result with the oldest item due
    task check_result(walk_out_t got);
      walk_out_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result kind=%0d %0d..%0d", got.kind,
                         got.first_pos, got.second_pos));
      end else begin
        want = due_results.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
        if (got.first_pos !== want.first_pos)
          report($sformatf("first_position %0d, want %0d", got.first_pos,
                           want.first_pos));
        if (got.second_pos !== want.second_pos)
          report($sformatf("second_position %0d, want %0d", got.second_pos,
                           want.second_pos));
        if (got.read_done !== want.read_done)
          report($sformatf("end_of_read %0d, want %0d", got.read_done,
                           want.read_done));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  junction_scoreboard sb;
  bit                 gaps_on;
  int                 ops_sent;

  cigar_splice_junction_walker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Drive one op on s_axis after a random gap (when gaps_on is set) and wait for its handshake
  task automatic send_op(logic [OpCodeW-1:0] code, logic [OpLenW-1:0] len,
                         logic first, logic last, logic [PosOutW-1:0] start);
    int gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, start, len, code};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.walk_op(code, len, first, last, start);
    ops_sent++;
  endtask

  function automatic logic [OpCodeW-1:0] rand_code();
    if ($urandom_range(0, 7) == 0)
      return OpCodeW'($urandom_range(OpUndefFirst, OpUndefLast));
    return OpCodeW'($urandom_range(OpMatch, OpSeqMism));
  endfunction

  function automatic logic [OpLenW-1:0] rand_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return LenMax;
    if (pick < 6) return OpLenW'($urandom);
    return OpLenW'($urandom_range(0, 500));
  endfunction

  // One well-formed read with random ops, or now and then a stray op
  task automatic send_read();
    int                 n_ops;
    logic [PosOutW-1:0] start;
    if ($urandom_range(0, 9) == 0) begin
      send_op(OpCodeW'($urandom), rand_len(), 1'($urandom), 1'($urandom),
              PosOutW'($urandom));
    end else begin
      n_ops = $urandom_range(1, 6);
      start = ($urandom_range(0, 3) == 0) ? PosOutW'($urandom)
                                          : PosOutW'($urandom_range(0, 100000));
      for (int i = 0; i < n_ops; i++) begin
        // bias toward skips so junctions are frequent
        send_op(($urandom_range(0, 2) == 0) ? OpSkip : rand_code(), rand_len(),
                i == 0, i == n_ops - 1, start);
      end
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Result side: random stalls while gaps_on is set, check each accepted item
  initial begin
    int        stall;
    walk_out_t got;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = gaps_on ? $urandom_range(0, 15) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.kind       = m_axis_tuser;
      got.first_pos  = m_axis_tdata[PosOutW-1:0];
      got.second_pos = m_axis_tdata[2*PosOutW-1:PosOutW];
      got.read_done  = m_axis_tlast;
      sb.check_result(got);
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus
  initial begin
    sb            = new();
    gaps_on       = 1'b0;
    ops_sent      = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // one-op read made of a skip: read end only
    send_op(OpSkip, 28'd100, 1'b1, 1'b1, 31'd1000);
    // skip inside a read gives a junction, skip at the end does not
    send_op(OpMatch, 28'd0, 1'b1, 1'b0, 31'd0);
    send_op(OpSkip, 28'd50, 1'b0, 1'b0, 31'd0);
    send_op(OpDel, 28'd10, 1'b0, 1'b0, 31'd0);
    send_op(OpSkip, 28'd5, 1'b0, 1'b1, 31'd0);
    // skip that opens a read; all the non-consuming ops
    send_op(OpSkip, 28'd20, 1'b1, 1'b0, 31'd4096);
    send_op(OpIns, 28'd7, 1'b0, 1'b0, 31'd0);
    send_op(OpSoft, 28'd7, 1'b0, 1'b0, 31'd0);
    send_op(OpHard, 28'd7, 1'b0, 1'b0, 31'd0);
    send_op(OpPad, 28'd7, 1'b0, 1'b0, 31'd0);
    send_op(OpSeqMatch, 28'd30, 1'b0, 1'b0, 31'd0);
    send_op(OpSeqMism, 28'd2, 1'b0, 1'b1, 31'd0);
    // undefined codes move nothing, a last one still ends the read
    send_op(OpMatch, 28'd40, 1'b1, 1'b0, 31'd77);
    send_op(OpUndefFirst, 28'd9, 1'b0, 1'b0, 31'd0);
    send_op(OpUndefLast, 28'd9, 1'b0, 1'b1, 31'd0);
    // saturation at the top of the position range
    send_op(OpMatch, 28'd5, 1'b1, 1'b0, StartMax - 31'd10);
    send_op(OpSkip, LenMax, 1'b0, 1'b0, 31'd0);
    send_op(OpSeqMism, LenMax, 1'b0, 1'b1, 31'd0);
    // read with no opening op continues from the kept state
    send_op(OpMatch, 28'd3, 1'b0, 1'b0, 31'd0);
    send_op(OpSkip, 28'd8, 1'b0, 1'b1, 31'd5);
    // extreme fields together
    send_op(OpSkip, LenMax, 1'b1, 1'b1, StartMax);
    send_op(OpMatch, LenMax, 1'b1, 1'b0, 31'd0);
    send_op(OpSkip, LenMax, 1'b0, 1'b1, StartMax);

    // random reads, idling switched in stretches
    gaps_on = 1'b1;
    ops_sent = 0;
    while (ops_sent < RandomOps) begin
      if ($urandom_range(0, 7) == 0) gaps_on = ~gaps_on;
      if (ops_sent >= RandomOps / 2 && ops_sent < RandomOps / 2 + 6) begin
        // hold off until every due item has come out
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        ops_sent = ops_sent + 6;
      end
      send_read();
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
